// ----- src/nearest_palette_color_l1_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the nearest palette colour core
// Clocked assertion helpers, with and without a reset disable.
// ----------------------------------------------------------------------------
`ifndef NEAREST_PALETTE_COLOR_L1_CORE_ASSERT_SVH
`define NEAREST_PALETTE_COLOR_L1_CORE_ASSERT_SVH

// Assertion sampled on the rising clock edge, off while reset is asserted
`define NPC_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion sampled on the rising clock edge, always on
`define NPC_ASSERT(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/npc_l1_pkg.sv -----
// ----------------------------------------------------------------------------
// npc_l1_pkg
// Shared types and constants of the nearest palette colour core.
// ----------------------------------------------------------------------------
package npc_l1_pkg;

  localparam int unsigned PALETTE_ENTRIES_DEF = 256;
  localparam int unsigned COLOUR_W = 24;
  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned IDX_W    = 8;
  localparam int unsigned DIST_W   = 10;

  // Search starts from the worst Manhattan distance and the top index
  localparam logic [DIST_W-1:0] START_DIST = 10'd765;
  localparam logic [IDX_W-1:0]  START_IDX  = 8'd255;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_MAP   = 1'b1
  } op_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_e;

  typedef struct packed {
    logic [DIST_W-1:0] dist_sum;
    logic              exact;
  } dist_res_t;

endpackage

// ----- src/npc_l1_if.sv -----
// ----------------------------------------------------------------------------
// npc_l1 channel interfaces
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface npc_l1_req_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] entry_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, opcode, entry_index, red, green, blue, input ready);
  modport sink   (input valid, opcode, entry_index, red, green, blue, output ready);
endinterface

interface npc_l1_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] palette_index;

  modport source (output valid, palette_index, input ready);
  modport sink   (input valid, palette_index, output ready);
endinterface

// ----- src/npc_l1_palette_mem.sv -----
// ----------------------------------------------------------------------------
// npc_l1_palette_mem
// Palette store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module npc_l1_palette_mem #(
  parameter int unsigned PALETTE_ENTRIES = npc_l1_pkg::PALETTE_ENTRIES_DEF,
  localparam int unsigned AW = $clog2(PALETTE_ENTRIES)
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [AW-1:0]                    waddr_i,
  input  logic [npc_l1_pkg::COLOUR_W-1:0]  wdata_i,
  input  logic                             re_i,
  input  logic [AW-1:0]                    raddr_i,
  output logic [npc_l1_pkg::COLOUR_W-1:0]  rdata_o
);

  logic [npc_l1_pkg::COLOUR_W-1:0] mem_q [PALETTE_ENTRIES];
  logic [npc_l1_pkg::COLOUR_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/npc_l1_dist_unit.sv -----
// ----------------------------------------------------------------------------
// npc_l1_dist_unit
// Shared Manhattan distance and exact-match unit, one entry per cycle.
// ----------------------------------------------------------------------------
module npc_l1_dist_unit (
  input  logic [npc_l1_pkg::COLOUR_W-1:0] entry_i,
  input  logic [npc_l1_pkg::COLOUR_W-1:0] pixel_i,
  output npc_l1_pkg::dist_res_t           res_o
);

  localparam int unsigned CW = npc_l1_pkg::CHAN_W;
  localparam int unsigned DW = npc_l1_pkg::DIST_W;

  logic [CW-1:0] dr, dg, db;

  function automatic logic [CW-1:0] abs_diff(input logic [CW-1:0] a, input logic [CW-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  always_comb begin
    dr = abs_diff(entry_i[3*CW-1:2*CW], pixel_i[3*CW-1:2*CW]);
    dg = abs_diff(entry_i[2*CW-1:CW],   pixel_i[2*CW-1:CW]);
    db = abs_diff(entry_i[CW-1:0],      pixel_i[CW-1:0]);
    res_o.dist_sum = DW'(dr) + DW'(dg) + DW'(db);
    res_o.exact    = (entry_i == pixel_i);
  end

endmodule

// ----- src/nearest_palette_color_l1_core.sv -----
// ----------------------------------------------------------------------------
// nearest_palette_color_l1_core
// Nearest palette colour search by Manhattan distance, with last-colour cache.
// ----------------------------------------------------------------------------
//  Channel | Dir | Payload                                  | Per request
//  req_i   | in  | opcode, entry_index, red, green, blue    | write or map
//  rsp_o   | out | palette_index                            | one per map
//
//  Palette write: accepted without a response.
//  Map, cache hit: response registered the cycle after acceptance.
//  Map, miss: a read lead-in, then one entry per cycle through the
//  single read port; the scan ends at the last entry or earlier on an
//  exact match, and the response is registered when the scan ends.
//  req_i.ready stays low throughout the scan.
//  Reset clears the cache to black / index 0; palette is undefined until
//  written. A pending response holds until taken and blocks the next request
//  unless it is taken in the same cycle.
// ----------------------------------------------------------------------------
module nearest_palette_color_l1_core #(
  parameter int unsigned PALETTE_ENTRIES = npc_l1_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  npc_l1_req_if.sink    req_i,
  npc_l1_rsp_if.source  rsp_o
);

  localparam int unsigned AW = $clog2(PALETTE_ENTRIES);
  localparam int unsigned CLW = npc_l1_pkg::COLOUR_W;
  localparam int unsigned IW = npc_l1_pkg::IDX_W;
  localparam int unsigned DW = npc_l1_pkg::DIST_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(PALETTE_ENTRIES - 1);

  npc_l1_pkg::state_e state_q, state_d;

  logic [CLW-1:0] pixel;
  logic           req_fire, is_map, is_write, hit, miss_start, out_free, in_range;
  logic           wr_fire, scanning;

  logic [CLW-1:0] cached_colour_q;
  logic [IW-1:0]  cached_index_q;
  logic [AW-1:0]  issue_q;
  logic           p_valid_q;
  logic [AW-1:0]  p_idx_q;
  logic [DW-1:0]  best_dist_q;
  logic [IW-1:0]  best_idx_q;
  logic           rsp_valid_q, rsp_valid_d;
  logic [IW-1:0]  rsp_data_q, rsp_data_d;

  logic [CLW-1:0]         rd_data;
  npc_l1_pkg::dist_res_t  dres;
  logic                   eval, closer, last, done;
  logic [IW-1:0]          result;

  // Request decode
  assign pixel    = {req_i.red, req_i.green, req_i.blue};
  assign req_fire = req_i.valid && req_i.ready;
  assign is_map   = (req_i.opcode == npc_l1_pkg::OP_MAP);
  assign is_write = (req_i.opcode == npc_l1_pkg::OP_WRITE);
  assign hit      = (pixel == cached_colour_q);
  assign miss_start = req_fire && is_map && !hit;
  assign out_free = !rsp_valid_q || rsp_o.ready;
  assign wr_fire  = req_fire && is_write;
  assign scanning = (state_q == npc_l1_pkg::ST_SCAN);
  // entries beyond the palette are dropped
  assign in_range = ({1'b0, req_i.entry_index} < 9'(PALETTE_ENTRIES));

  npc_l1_palette_mem #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (req_fire && is_write && in_range),
    .waddr_i (req_i.entry_index[AW-1:0]),
    .wdata_i (pixel),
    .re_i    (state_q == npc_l1_pkg::ST_SCAN),
    .raddr_i (issue_q),
    .rdata_o (rd_data)
  );

  // Pixel under search is the freshly cached colour
  npc_l1_dist_unit u_dist (
    .entry_i (rd_data),
    .pixel_i (cached_colour_q),
    .res_o   (dres)
  );

  // Evaluate the entry whose read data has just landed
  assign eval   = (state_q == npc_l1_pkg::ST_SCAN) && p_valid_q;
  assign closer = (dres.dist_sum < best_dist_q);
  assign last   = (p_idx_q == LAST_ADDR);
  assign done   = eval && (dres.exact || last);
  assign result = (dres.exact || closer) ? IW'(p_idx_q) : best_idx_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      npc_l1_pkg::ST_IDLE: begin
        if (miss_start) begin
          state_d = npc_l1_pkg::ST_SCAN;
        end
      end
      npc_l1_pkg::ST_SCAN: begin
        if (done) begin
          state_d = npc_l1_pkg::ST_IDLE;
        end
      end
      default: state_d = npc_l1_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    req_i.ready = 1'b0;
    unique case (state_q)
      npc_l1_pkg::ST_IDLE: req_i.ready = out_free;
      npc_l1_pkg::ST_SCAN: req_i.ready = 1'b0;
      default:             req_i.ready = 1'b0;
    endcase
  end

  // Response register
  always_comb begin
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    rsp_data_d  = rsp_data_q;
    if (req_fire && is_map && hit) begin
      rsp_valid_d = 1'b1;
      rsp_data_d  = cached_index_q;
    end else if (done) begin
      rsp_valid_d = 1'b1;
      rsp_data_d  = result;
    end
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.palette_index = rsp_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= npc_l1_pkg::ST_IDLE;
      cached_colour_q <= '0;
      cached_index_q  <= '0;
      issue_q         <= '0;
      p_valid_q       <= 1'b0;
      rsp_valid_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
      p_valid_q   <= (state_q == npc_l1_pkg::ST_SCAN) && !done;
      if (miss_start) begin
        cached_colour_q <= pixel;
        issue_q         <= '0;
      end else if ((state_q == npc_l1_pkg::ST_SCAN) && (issue_q != LAST_ADDR)) begin
        issue_q <= issue_q + AW'(1);
      end
      if (done) begin
        cached_index_q <= result;
      end
    end
  end

  // Datapath registers, no reset
  always_ff @(posedge clk_i) begin
    rsp_data_q <= rsp_data_d;
    p_idx_q    <= issue_q;
    if (miss_start) begin
      best_dist_q <= npc_l1_pkg::START_DIST;
      best_idx_q  <= npc_l1_pkg::START_IDX;
    end else if (eval && closer) begin
      best_dist_q <= dres.dist_sum;
      best_idx_q  <= IW'(p_idx_q);
    end
  end

  // Checks
`include "nearest_palette_color_l1_core_assert.svh"

  `NPC_ASSERT_RST(a_write_no_rsp, clk_i, rst_ni, wr_fire |=> !rsp_o.valid, "write gave a response")
  `NPC_ASSERT_RST(a_miss_scans, clk_i, rst_ni, miss_start |=> scanning, "miss did not start a scan")
  `NPC_ASSERT_RST(a_scan_no_rsp, clk_i, rst_ni, scanning |-> !rsp_o.valid, "response during scan")
  `NPC_ASSERT(a_reset_idle, clk_i, !rst_ni |-> !scanning, "not idle in reset")

endmodule
